FILE: rtl/core/rled_pkg.sv
package rled_pkg;

   // widths of the run counter and of the compressed length
   localparam int COUNT_BITS  = 16;
   localparam int LENGTH_BITS = 32;

   // decimal digits kept for a run count
   localparam int DIGITS     = 5;
   localparam int NDIG_W     = $clog2(DIGITS + 1);

   // a run closes at the smaller of the counter maximum and five decimal nines
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam longint unsigned DEC_MAX   = 64'd99999;
   localparam longint unsigned CAP_WIDE  = (COUNT_MAX < DEC_MAX) ? COUNT_MAX : DEC_MAX;
   localparam logic [COUNT_BITS-1:0] RUN_CAP = CAP_WIDE[COUNT_BITS-1:0];

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   typedef logic [DIGITS-1:0][3:0] bcd_type;

   localparam bcd_type BCD_ONE = bcd_type'(1);

   // one run waiting to go out: its byte, its count in decimal, digits to send
   typedef struct packed {
      logic [7:0]        run_byte;
      bcd_type           bcd;
      logic [NDIG_W-1:0] ndig;
   } seg_type;

   // work handed from the run tracker to the emitter
   typedef struct packed {
      seg_type cur;
      seg_type nxt;
      logic    nxt_valid;
      logic    is_end;
   } job_type;

   // emitter status back to the run tracker
   typedef struct packed {
      logic busy;
      logic final_pop;
   } emit_status_type;

   // decimal increment across all digits
   function automatic bcd_type bcd_inc(input bcd_type v);
      bcd_type r;
      logic    carry;
      r     = v;
      carry = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         if (carry) begin
            if (r[i] == 4'd9) begin
               r[i] = 4'd0;
            end else begin
               r[i]  = r[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   // number of significant digits, or none for a single byte run
   function automatic logic [NDIG_W-1:0] count_digits(input bcd_type v, input logic multi);
      logic [NDIG_W-1:0] n;
      n = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (v[i] != 4'd0) begin
            n = NDIG_W'(i + 1);
         end
      end
      return multi ? n : '0;
   endfunction

endpackage

FILE: rtl/core/run_length_encoder_decimal.sv
// channel | direction | handshake            | word
// req     | in        | req_valid, req_stall | req_in_byte, req_stream_end
// rsp     | out       | rsp_valid, rsp_stall | rsp_out_byte, rsp_item_last,
//         |           |                      | rsp_stream_done, rsp_stream_length
//
// A byte that only extends the open run is taken every cycle and gives no word.
// A byte that closes a run gives one word per cycle from the emitter while rsp_stall is low: the run
// byte and up to five count digits, two runs (up to seven words) at end of stream.
// req_stall rises only for a byte that gives words while the emitter has words
// left and its final one is not taken in that cycle; a new burst loads as it is.
// Synchronous reset clears the open run, the emitter and the length count.
module run_length_encoder_decimal
   import rled_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_stream_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_item_last,
   output logic                   rsp_stream_done,
   output logic [LENGTH_BITS-1:0] rsp_stream_length
);

   logic [7:0]            run_char_ff, run_char_in;
   logic                  run_active_ff, run_active_in;
   logic [COUNT_BITS-1:0] run_len_ff, run_len_in;
   bcd_type               run_bcd_ff, run_bcd_in;

   logic                  extend;
   logic                  flush_old;
   logic                  produce;
   logic                  accept;
   logic                  load;
   bcd_type               new_bcd;
   seg_type               seg_old;
   seg_type               seg_new;
   job_type               job;
   emit_status_type       status;

   // does this byte extend the open run
   assign extend    = run_active_ff && (req_in_byte == run_char_ff) && (run_len_ff != RUN_CAP);
   assign flush_old = run_active_ff && !extend;
   assign produce   = flush_old || req_stream_end;
   assign new_bcd   = extend ? bcd_inc(run_bcd_ff) : BCD_ONE;

   // runs to send: the closed one and, at end of stream, the open one
   always_comb begin
      seg_old.run_byte = run_char_ff;
      seg_old.bcd      = run_bcd_ff;
      seg_old.ndig     = count_digits(run_bcd_ff, run_len_ff > COUNT_BITS'(1));
      seg_new.run_byte = extend ? run_char_ff : req_in_byte;
      seg_new.bcd      = new_bcd;
      seg_new.ndig     = count_digits(new_bcd, extend);
      job.cur          = flush_old ? seg_old : seg_new;
      job.nxt          = seg_new;
      job.nxt_valid    = flush_old && req_stream_end;
      job.is_end       = req_stream_end;
   end

   // hold back only a byte that needs the emitter while it is still busy
   assign req_stall = produce && status.busy && !status.final_pop;
   assign accept    = req_valid && !req_stall;
   assign load      = accept && produce;

   // open run update, cleared after the final byte of a stream
   always_comb begin
      run_char_in   = run_char_ff;
      run_active_in = run_active_ff;
      run_len_in    = run_len_ff;
      run_bcd_in    = run_bcd_ff;
      if (accept) begin
         if (req_stream_end) begin
            run_char_in   = '0;
            run_active_in = 1'b0;
            run_len_in    = '0;
            run_bcd_in    = '0;
         end else begin
            run_char_in   = seg_new.run_byte;
            run_active_in = 1'b1;
            run_len_in    = extend ? run_len_ff + 1'b1 : COUNT_BITS'(1);
            run_bcd_in    = new_bcd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_char_ff   <= '0;
         run_active_ff <= 1'b0;
         run_len_ff    <= '0;
         run_bcd_ff    <= '0;
      end else begin
         run_char_ff   <= run_char_in;
         run_active_ff <= run_active_in;
         run_len_ff    <= run_len_in;
         run_bcd_ff    <= run_bcd_in;
      end
   end

   // word sequencer and result register
   rled_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .job               (job),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_item_last     (rsp_item_last),
      .rsp_stream_done   (rsp_stream_done),
      .rsp_stream_length (rsp_stream_length)
   );

endmodule

FILE: rtl/core/rled_emit.sv
module rled_emit
   import rled_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  job_type                job,
   output emit_status_type        status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_item_last,
   output logic                   rsp_stream_done,
   output logic [LENGTH_BITS-1:0] rsp_stream_length
);

   seg_type                cur_ff, cur_in;
   seg_type                nxt_ff, nxt_in;
   logic                   nxt_valid_ff, nxt_valid_in;
   logic                   end_ff, end_in;
   logic                   busy_ff, busy_in;
   logic [NDIG_W-1:0]      pos_ff, pos_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;

   logic                   pop;
   logic                   seg_last;
   logic                   item_last;
   logic                   done;
   logic [NDIG_W-1:0]      dig_sel;
   logic [3:0]             digit;
   logic [LENGTH_BITS-1:0] total_inc;

   // position within the current run: byte first, then digits high to low
   assign pop       = busy_ff && !rsp_stall;
   assign seg_last  = (pos_ff == cur_ff.ndig);
   assign item_last = seg_last && !nxt_valid_ff;
   assign done      = item_last && end_ff;
   assign dig_sel   = cur_ff.ndig - pos_ff;

   // digit pick, out of range only while the run byte itself is shown
   always_comb begin
      unique case (dig_sel)
         3'd0:    digit = cur_ff.bcd[0];
         3'd1:    digit = cur_ff.bcd[1];
         3'd2:    digit = cur_ff.bcd[2];
         3'd3:    digit = cur_ff.bcd[3];
         3'd4:    digit = cur_ff.bcd[4];
         default: digit = 4'd0;
      endcase
   end

   // saturating count of words sent in this stream, including the current one
   assign total_inc = (total_ff == {LENGTH_BITS{1'b1}}) ? total_ff : total_ff + 1'b1;

   // result word
   assign rsp_valid         = busy_ff;
   assign rsp_out_byte      = (pos_ff == '0) ? cur_ff.run_byte : (ASCII_ZERO | {4'd0, digit});
   assign rsp_item_last     = item_last;
   assign rsp_stream_done   = done;
   assign rsp_stream_length = done ? total_inc : '0;

   assign status.busy      = busy_ff;
   assign status.final_pop = pop && item_last;

   // walk through one or two runs, reload straight after the last word
   always_comb begin
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      nxt_valid_in = nxt_valid_ff;
      end_in       = end_ff;
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      if (pop) begin
         total_in = done ? '0 : total_inc;
         if (!seg_last) begin
            pos_in = pos_ff + 1'b1;
         end else if (nxt_valid_ff) begin
            cur_in       = nxt_ff;
            nxt_valid_in = 1'b0;
            pos_in       = '0;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         cur_in       = job.cur;
         nxt_in       = job.nxt;
         nxt_valid_in = job.nxt_valid;
         end_in       = job.is_end;
         busy_in      = 1'b1;
         pos_in       = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         nxt_valid_ff <= 1'b0;
         pos_ff       <= '0;
         total_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         nxt_valid_ff <= nxt_valid_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      end_ff <= end_in;
   end

endmodule

FILE: rtl/core/rled_check.sv
module rled_check
   import rled_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_item_last,
   input logic                   rsp_stream_done,
   input logic [LENGTH_BITS-1:0] rsp_stream_length
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // the end of a stream is also the end of its byte's burst
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_item_last)
      else $error("stream done without item last");

   // length shows only on the final word
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stream_done |-> rsp_stream_length == '0)
      else $error("stream length shown before end of stream");

   // a burst goes out without gaps
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_item_last |=> rsp_valid)
      else $error("gap inside a burst");

endmodule

bind run_length_encoder_decimal rled_check u_check (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rled_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;

   // one compressed word as it leaves the block
   typedef struct {
      logic [7:0]             out_byte;
      logic                   item_last;
      logic                   stream_done;
      logic [LENGTH_BITS-1:0] stream_length;
   } rle_word_type;

   // tracks the open run and holds the compressed words still to come
   class rle_scoreboard;
      logic [7:0]             run_char;
      bit                     run_open;
      logic [COUNT_BITS-1:0]  run_count;
      logic [LENGTH_BITS-1:0] total;
      rle_word_type           burst[$];
      rle_word_type           words_due[$];
      int                     errors;

      function new();
         restart();
         errors = 0;
      endfunction

      function void restart();
         run_char  = '0;
         run_open  = 0;
         run_count = '0;
         total     = '0;
      endfunction

      function void put_byte(logic [7:0] b);
         rle_word_type w;
         w.out_byte      = b;
         w.item_last     = 1'b0;
         w.stream_done   = 1'b0;
         w.stream_length = '0;
         burst.push_back(w);
         // length count saturates
         if (total != '1) total++;
      endfunction

      // run byte then its count in decimal, most significant digit first
      function void close_run();
         logic [7:0]  digs[$];
         int unsigned v;
         v = 32'(run_count);
         put_byte(run_char);
         if (run_count > 1) begin
            while (v > 0) begin
               digs.push_front(ASCII_ZERO + 8'(v % 10));
               v = v / 10;
            end
            foreach (digs[i]) put_byte(digs[i]);
         end
      endfunction

      function void encode_byte(logic [7:0] b, logic last_in);
         rle_word_type w;
         burst.delete();
         // extend the run, or close it (also when it sits at the cap)
         if (run_open && b == run_char && run_count < RUN_CAP) begin
            run_count++;
         end else begin
            if (run_open) close_run();
            run_char  = b;
            run_count = 1;
            run_open  = 1;
         end
         // end of stream flushes the run and reports the length
         if (last_in) begin
            close_run();
            w               = burst[$];
            w.stream_done   = 1'b1;
            w.stream_length = total;
            burst[$]        = w;
            restart();
         end
         if (burst.size() > 0) begin
            w           = burst[$];
            w.item_last = 1'b1;
            burst[$]    = w;
         end
         foreach (burst[i]) words_due.push_back(burst[i]);
      endfunction

      function void check_word(logic [7:0] ob, logic il, logic sd,
                               logic [LENGTH_BITS-1:0] sl);
         rle_word_type w;
         if (words_due.size() == 0) begin
            $error("unexpected word: out_byte %0h", ob);
            errors++;
            return;
         end
         w = words_due.pop_front();
         if (ob !== w.out_byte) begin
            $error("out_byte: expected %0h, got %0h", w.out_byte, ob);
            errors++;
         end
         if (il !== w.item_last) begin
            $error("item_last: expected %0b, got %0b", w.item_last, il);
            errors++;
         end
         if (sd !== w.stream_done) begin
            $error("stream_done: expected %0b, got %0b", w.stream_done, sd);
            errors++;
         end
         if (sl !== w.stream_length) begin
            $error("stream_length: expected %0d, got %0d", w.stream_length, sl);
            errors++;
         end
      endfunction

      function int pending();
         return words_due.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_in_byte = 8'h00;
   logic                   req_stream_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_item_last;
   logic                   rsp_stream_done;
   logic [LENGTH_BITS-1:0] rsp_stream_length;

   rle_scoreboard sb = new();
   bit            calm = 1'b0;
   int unsigned   cycle_count = 0;
   int unsigned   bytes_sent = 0;

   run_length_encoder_decimal dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_item_last     (rsp_item_last),
      .rsp_stream_done   (rsp_stream_done),
      .rsp_stream_length (rsp_stream_length)
   );

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // both handshakes sampled at the edge, before any update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            sb.encode_byte(req_in_byte, req_stream_end);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            sb.check_word(rsp_out_byte, rsp_item_last, rsp_stream_done, rsp_stream_length);
         end
      end
   end

   // receiver back-pressure, a fresh wait drawn for every word
   initial begin
      int n;
      forever begin
         n = calm ? 0 : $urandom_range(0, 14);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // present one byte after a random gap and wait until it is taken
   task automatic send_item(logic [7:0] b, logic last_in);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_stream_end <= last_in;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   task automatic send_run(logic [7:0] b, int len, logic last_in);
      for (int k = 0; k < len; k++) begin
         send_item(b, last_in && (k == len - 1));
      end
   endtask

   // hold the input until every outstanding word has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // well-formed stream of random runs, mostly short
   task automatic random_stream();
      int         nruns;
      int         len;
      int         pick;
      logic [7:0] b;
      nruns = $urandom_range(1, 8);
      for (int r = 0; r < nruns; r++) begin
         pick = $urandom_range(0, 3);
         if (pick < 2) b = 8'($urandom_range(0, 255));
         else if (pick == 2) b = 8'($urandom_range(8'h30, 8'h39));
         else b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         pick = $urandom_range(0, 99);
         if (pick < 60) len = $urandom_range(1, 3);
         else if (pick < 92) len = $urandom_range(4, 15);
         else len = $urandom_range(16, 130);
         send_run(b, len, r == nruns - 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-byte streams at the byte extremes
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      // run ending on the final byte
      send_run(8'h55, 3, 1'b1);
      // final byte closes a run and is its own run
      send_item(8'hAA, 1'b0);
      send_item(8'h55, 1'b1);
      // digit-valued bytes, several words from one byte
      send_item(8'h30, 1'b0);
      send_run(8'h31, 2, 1'b0);
      send_item(8'h39, 1'b1);
      // count with a zero digit
      send_run(8'h7E, 10, 1'b1);
      send_item(8'h80, 1'b0);
      send_item(8'h01, 1'b1);
      drain();

      // long run at full rate: three digits, then a new byte at stream end
      calm = 1'b1;
      send_run(8'h6B, 100, 1'b0);
      send_item(8'h71, 1'b1);
      calm = 1'b0;

      // random streams, idle and calm stretches mixed
      while (bytes_sent < 480) begin
         if ($urandom_range(0, 4) == 0) calm = ~calm;
         random_stream();
         if ($urandom_range(0, 9) == 0) drain();
      end
      calm = 1'b0;

      drain();
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
